[hdl/rrls_pkg.sv]
package rrls_pkg;

  localparam int PALETTE_ENTRIES_DEF = 32;

  localparam int SQ_W   = 34;
  localparam int ROOT_W = 17;
  localparam int REM_W  = ROOT_W + 2;

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RING_RADIUS,
    REG_FADE_WIDTH,
    REG_COLOR_A,
    REG_COLOR_B,
    REG_WINDOW_WIDTH,
    REG_BRIGHTNESS_LIMITS
  } rrls_reg_t;

  localparam logic [15:0] FADE_WIDTH_RST        = 16'd256;
  localparam logic [23:0] COLOR_B_RST           = 24'hFFFFFF;
  localparam logic [7:0]  WINDOW_WIDTH_RST      = 8'd16;
  localparam logic [15:0] BRIGHTNESS_LIMITS_RST = 16'h8000;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] ring_radius;
    logic [15:0]        fade_width;
    logic [23:0]        color_a;
    logic [23:0]        color_b;
    logic [7:0]         window_width;
    logic [15:0]        brightness_limits;
  } rrls_cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic [7:0]      ws;
  } rrls_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rrls_fifo_status_t;

  // Two-colour blend of one channel, f selects the share of b.
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] f);
    logic [7:0]  d;
    logic [16:0] p;
    d = (b > a) ? (b - a) : (a - b);
    p = d * ({1'b0, f} + 9'd1);
    return (b > a) ? (a + p[15:8]) : (a - p[15:8]);
  endfunction

endpackage

[hdl/radial_ring_led_shader.sv]
// Radial ring LED shader: one LED position in, one RGB colour out.
// Throughput: one item per cycle; the square root and the fade division are
// fully pipelined, one result bit per stage, so busy never holds off start.
// Reset: synchronous, active high; clears the pipeline and restores register defaults.
// The receiver cannot stall: each result is shown for one cycle with done.
module radial_ring_led_shader import rrls_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] led_x,
  input  logic signed [15:0] led_y,
  input  logic [7:0]         window_start,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  rrls_cfg_t         cfg;
  rrls_item_t        f_item, q_head;
  rrls_fifo_status_t q_st;
  logic              f_push, b_pop, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x          <= '0;
      cfg.center_y          <= '0;
      cfg.ring_radius       <= '0;
      cfg.fade_width        <= FADE_WIDTH_RST;
      cfg.color_a           <= '0;
      cfg.color_b           <= COLOR_B_RST;
      cfg.window_width      <= WINDOW_WIDTH_RST;
      cfg.brightness_limits <= BRIGHTNESS_LIMITS_RST;
    end else if (cfg_write) begin
      case (rrls_reg_t'(cfg_index))
        REG_CENTER_X:          cfg.center_x          <= cfg_data[15:0];
        REG_CENTER_Y:          cfg.center_y          <= cfg_data[15:0];
        REG_RING_RADIUS:       cfg.ring_radius       <= cfg_data[15:0];
        REG_FADE_WIDTH:        cfg.fade_width        <= cfg_data[15:0];
        REG_COLOR_A:           cfg.color_a           <= cfg_data;
        REG_COLOR_B:           cfg.color_b           <= cfg_data;
        REG_WINDOW_WIDTH:      cfg.window_width      <= cfg_data[7:0];
        REG_BRIGHTNESS_LIMITS: cfg.brightness_limits <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy   = q_st.full;
  assign accept = start && !busy;

  rrls_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .led_x        (led_x),
    .led_y        (led_y),
    .window_start (window_start),
    .cfg          (cfg),
    .push         (f_push),
    .item         (f_item)
  );

  rrls_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .wdata  (f_item),
    .pop    (b_pop),
    .rdata  (q_head),
    .status (q_st)
  );

  rrls_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .fifo_st (q_st),
    .head    (q_head),
    .pop     (b_pop),
    .cfg     (cfg),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue)
  );

endmodule

[hdl/rrls_front.sv]
module rrls_front import rrls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] led_x,
  input  logic signed [15:0] led_y,
  input  logic [7:0]         window_start,
  input  rrls_cfg_t          cfg,
  output logic               push,
  output rrls_item_t         item
);

  logic               v1, v2;
  logic signed [16:0] dx, dy;
  logic [7:0]         ws1, ws2;
  logic [32:0]        sqx, sqy;
  logic signed [33:0] px, py;

  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= {led_x[15], led_x} - {cfg.center_x[15], cfg.center_x};
    dy  <= {led_y[15], led_y} - {cfg.center_y[15], cfg.center_y};
    ws1 <= window_start;
    sqx <= px[32:0];
    sqy <= py[32:0];
    ws2 <= ws1;
  end

  assign push    = v2;
  assign item.sq = {1'b0, sqx} + {1'b0, sqy};
  assign item.ws = ws2;

endmodule

[hdl/rrls_fifo.sv]
module rrls_fifo import rrls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrls_item_t        wdata,
  input  logic              pop,
  output rrls_item_t        rdata,
  output rrls_fifo_status_t status
);

  rrls_item_t  slot [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wdata;
  end

  assign rdata        = slot[rptr];
  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);

endmodule

[hdl/rrls_back.sv]
module rrls_back import rrls_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rrls_fifo_status_t fifo_st,
  input  rrls_item_t        head,
  output logic              pop,
  input  rrls_cfg_t         cfg,
  output logic              done,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  localparam int IW  = $clog2(PALETTE_ENTRIES);
  localparam int RSH = 18;
  localparam logic [RSH-1:0] RECIP = RSH'((1 << RSH) / PALETTE_ENTRIES);
  localparam logic [8:0]     NC    = 9'(PALETTE_ENTRIES);

  logic [15:0] fw;
  logic [7:0]  ww_m1, minb, maxb, span;

  assign fw    = (cfg.fade_width == 16'd0) ? 16'd1 : cfg.fade_width;
  assign ww_m1 = ((cfg.window_width == 8'd0) ? 8'd16 : cfg.window_width) - 8'd1;
  assign minb  = cfg.brightness_limits[7:0];
  assign maxb  = cfg.brightness_limits[15:8];
  assign span  = (maxb > minb) ? (maxb - minb) : 8'd0;

  assign pop = !fifo_st.empty;

  // Square root, one result bit per stage.
  logic              sv      [18];
  logic [SQ_W-1:0]   sr_v    [18];
  logic [REM_W-1:0]  sr_rem  [18];
  logic [ROOT_W-1:0] sr_root [18];
  logic [7:0]        sr_ws   [18];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else     sv[0] <= pop;
  end

  always_ff @(posedge clk) begin
    sr_v[0]    <= head.sq;
    sr_rem[0]  <= '0;
    sr_root[0] <= '0;
    sr_ws[0]   <= head.ws;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int LO = 2 * (ROOT_W - 1 - k);
    logic [REM_W-1:0] cat, trial;
    logic             ge;
    assign cat   = {sr_rem[k][REM_W-3:0], sr_v[k][LO+1:LO]};
    assign trial = {sr_root[k], 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else     sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      sr_v[k+1]    <= sr_v[k];
      sr_rem[k+1]  <= ge ? (cat - trial) : cat;
      sr_root[k+1] <= {sr_root[k][ROOT_W-2:0], ge};
      sr_ws[k+1]   <= sr_ws[k];
    end
  end

  // Distance from the ring and saturation of the blend.
  logic signed [18:0] delta;
  logic [17:0]        adiff;
  logic               dv;
  logic [15:0]        d_rem;
  logic               d_sat;
  logic [7:0]         d_ws;

  assign delta = $signed({2'b00, sr_root[ROOT_W]})
               - $signed({{3{cfg.ring_radius[15]}}, cfg.ring_radius});
  assign adiff = delta[18] ? 18'(-delta) : delta[17:0];

  always_ff @(posedge clk) begin
    if (rst) dv <= 1'b0;
    else     dv <= sv[ROOT_W];
  end

  always_ff @(posedge clk) begin
    d_rem <= adiff[15:0];
    d_sat <= (adiff >= {2'b00, fw});
    d_ws  <= sr_ws[ROOT_W];
  end

  // Restoring division of the remaining distance by the fade width.
  logic        dvv  [17];
  logic [15:0] drem [17];
  logic [15:0] dq   [17];
  logic        dsat [17];
  logic [7:0]  dws  [17];

  assign dvv[0]  = dv;
  assign drem[0] = d_rem;
  assign dq[0]   = '0;
  assign dsat[0] = d_sat;
  assign dws[0]  = d_ws;

  for (genvar j = 0; j < 16; j++) begin : g_div
    logic [16:0] sh, dif;
    logic        ge;
    assign sh  = {drem[j], 1'b0};
    assign dif = sh - {1'b0, fw};
    assign ge  = (sh >= {1'b0, fw});

    always_ff @(posedge clk) begin
      if (rst) dvv[j+1] <= 1'b0;
      else     dvv[j+1] <= dvv[j];
    end

    always_ff @(posedge clk) begin
      drem[j+1] <= ge ? dif[15:0] : sh[15:0];
      dq[j+1]   <= {dq[j][14:0], ge};
      dsat[j+1] <= dsat[j];
      dws[j+1]  <= dws[j];
    end
  end

  // Fade and palette offset.
  logic [16:0] blend, inv;
  logic [33:0] inv_sq;
  logic [24:0] offs_p;
  logic        va;
  logic [16:0] fade_a;
  logic [8:0]  offs_a;
  logic [7:0]  ws_a;

  assign blend  = dsat[16] ? 17'h10000 : {1'b0, dq[16]};
  assign inv    = 17'h10000 - blend;
  assign inv_sq = inv * inv;
  assign offs_p = blend * ww_m1;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= dvv[16];
  end

  always_ff @(posedge clk) begin
    fade_a <= inv_sq[32:16];
    offs_a <= offs_p[24:16];
    ws_a   <= dws[16];
  end

  // Palette index estimate and brightness product.
  logic [8:0]  v_sum;
  logic [26:0] q_p;
  logic [24:0] f_p;
  logic        vb;
  logic [8:0]  v_b, qe_b, fp_b;

  assign v_sum = {1'b0, ws_a} + offs_a;
  assign q_p   = v_sum * RECIP;
  assign f_p   = fade_a * span;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
  end

  always_ff @(posedge clk) begin
    v_b  <= v_sum;
    qe_b <= q_p[26:18];
    fp_b <= f_p[24:16];
  end

  // The reciprocal estimate is at most one short; one correction settles it.
  logic [17:0] qn;
  logic [9:0]  r, rc;
  logic        vc;
  logic [IW-1:0] idx_c;
  logic [7:0]  br_c;

  assign qn = qe_b * NC;
  assign r  = {1'b0, v_b} - qn[9:0];
  assign rc = (r >= {1'b0, NC}) ? (r - {1'b0, NC}) : r;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
  end

  always_ff @(posedge clk) begin
    idx_c <= rc[IW-1:0];
    br_c  <= minb + fp_b[7:0];
  end

  // Triangle palette weights.
  logic [7:0] ftab [PALETTE_ENTRIES];
  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_pal
    localparam int FV = (2 * g < PALETTE_ENTRIES - 1)
                      ? (510 * g) / (PALETTE_ENTRIES - 1)
                      : (510 * (PALETTE_ENTRIES - 1 - g)) / (PALETTE_ENTRIES - 1);
    assign ftab[g] = 8'(FV);
  end

  logic       vd;
  logic [7:0] ch_d [3];
  logic [7:0] br_d;
  logic [7:0] f_c;

  assign f_c = ftab[idx_c];

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else     vd <= vc;
  end

  always_ff @(posedge clk) begin
    ch_d[0] <= lerp8(cfg.color_a[23:16], cfg.color_b[23:16], f_c);
    ch_d[1] <= lerp8(cfg.color_a[15:8],  cfg.color_b[15:8],  f_c);
    ch_d[2] <= lerp8(cfg.color_a[7:0],   cfg.color_b[7:0],   f_c);
    br_d    <= br_c;
  end

  // Video scaling keeps a lit channel from going dark.
  logic [15:0] vp [3];
  logic [7:0]  vo [3];
  for (genvar c = 0; c < 3; c++) begin : g_video
    assign vp[c] = ch_d[c] * br_d;
    assign vo[c] = (br_d == 8'd0) ? 8'd0 : (vp[c][15:8] + {7'd0, (ch_d[c] != 8'd0)});
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd;
  end

  always_ff @(posedge clk) begin
    red   <= vo[0];
    green <= vo[1];
    blue  <= vo[2];
  end

  logic [35:0] root_lo, root_hi;
  assign root_lo = {19'd0, sr_root[ROOT_W]} * {19'd0, sr_root[ROOT_W]};
  assign root_hi = ({19'd0, sr_root[ROOT_W]} + 36'd1) * ({19'd0, sr_root[ROOT_W]} + 36'd1);

  a_root: assert property (@(posedge clk) disable iff (rst)
    sv[ROOT_W] |-> (root_lo <= {2'b00, sr_v[ROOT_W]}) && (root_hi > {2'b00, sr_v[ROOT_W]}))
    else $error("square root out of range");

  a_index: assert property (@(posedge clk) disable iff (rst)
    vb |=> ({{(10-IW){1'b0}}, idx_c} < {1'b0, NC}))
    else $error("palette index beyond palette");

  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vd))
    else $error("result strobe without an item");

endmodule

[test/tb_radial_ring_led_shader.sv]
module tb_radial_ring_led_shader;
  import rrls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 42;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_ENTRIES = PALETTE_ENTRIES_DEF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] led_x = '0;
  logic signed [15:0] led_y = '0;
  logic [7:0]         window_start = '0;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               done;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;

  rrls_cfg_t shadow_cfg;
  rgb_t      pending_colours[$];
  int        errors = 0;
  int        idle_cycles = 0;

  radial_ring_led_shader u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
                                               input int f);
    int d;
    d = (b > a) ? b - a : a - b;
    d = (d * (f + 1)) >> 8;
    return (b > a) ? a + d : a - d;
  endfunction

  function automatic rgb_t shade_led(input logic signed [15:0] x,
                                     input logic signed [15:0] y, input logic [7:0] ws);
    longint dx, dy, sq, root, delta, fw, blend, fade, ww, idx, f, span, lo, hi;
    logic [7:0] ch[3];
    logic [7:0] br;
    rgb_t c;
    dx = longint'(x) - longint'(shadow_cfg.center_x);
    dy = longint'(y) - longint'(shadow_cfg.center_y);
    sq = dx * dx + dy * dy;
    // Floor square root by binary search; sq fits in 34 bits.
    lo = 0;
    hi = 262144;
    while (hi - lo > 1) begin
      root = (lo + hi) / 2;
      if (root * root <= sq) lo = root; else hi = root;
    end
    delta = lo - longint'(shadow_cfg.ring_radius);
    if (delta < 0) delta = -delta;
    fw = (shadow_cfg.fade_width == 0) ? 1 : shadow_cfg.fade_width;
    blend = (delta >= fw) ? 65536 : (delta << 16) / fw;
    fade = ((65536 - blend) * (65536 - blend)) >> 16;
    ww = (shadow_cfg.window_width == 0) ? 16 : shadow_cfg.window_width;
    idx = (ws + ((blend * (ww - 1)) >> 16)) % N_ENTRIES;
    if (2 * idx < N_ENTRIES - 1) f = (510 * idx) / (N_ENTRIES - 1);
    else f = (510 * (N_ENTRIES - 1 - idx)) / (N_ENTRIES - 1);
    for (int k = 0; k < 3; k++)
      ch[k] = blend_channel(shadow_cfg.color_a[16-8*k +: 8],
                            shadow_cfg.color_b[16-8*k +: 8], int'(f));
    lo = shadow_cfg.brightness_limits[7:0];
    hi = shadow_cfg.brightness_limits[15:8];
    span = (hi > lo) ? hi - lo : 0;
    br = 8'(lo + ((fade * span) >> 16));
    for (int k = 0; k < 3; k++)
      if (br == 0) ch[k] = 8'd0;
      else ch[k] = 8'(((int'(ch[k]) * br) >> 8) + (ch[k] != 0 ? 1 : 0));
    c.red = ch[0];
    c.green = ch[1];
    c.blue = ch[2];
    return c;
  endfunction

  // Result checker and watchdog.
  always @(posedge clk) begin
    rgb_t exp_c;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (pending_colours.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          exp_c = pending_colours.pop_front();
          if (red !== exp_c.red) begin
            $error("red expected %0d actual %0d", exp_c.red, red);
            errors++;
          end
          if (green !== exp_c.green) begin
            $error("green expected %0d actual %0d", exp_c.green, green);
            errors++;
          end
          if (blue !== exp_c.blue) begin
            $error("blue expected %0d actual %0d", exp_c.blue, blue);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_radial_ring_led_shader failed");
        $finish;
      end
    end
  end

  // Sends one LED; start stays high while further items follow in the burst.
  task automatic send_led(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic [7:0] ws, input bit hold);
    start <= 1'b1;
    led_x <= x;
    led_y <= y;
    window_start <= ws;
    do @(posedge clk); while (busy);
    pending_colours.push_back(shade_led(x, y, ws));
    @(negedge clk);
    if (!hold) start <= 1'b0;
  endtask

  task automatic write_reg(input rrls_reg_t idx, input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CENTER_X:          shadow_cfg.center_x = val[15:0];
      REG_CENTER_Y:          shadow_cfg.center_y = val[15:0];
      REG_RING_RADIUS:       shadow_cfg.ring_radius = val[15:0];
      REG_FADE_WIDTH:        shadow_cfg.fade_width = val[15:0];
      REG_COLOR_A:           shadow_cfg.color_a = val;
      REG_COLOR_B:           shadow_cfg.color_b = val;
      REG_WINDOW_WIDTH:      shadow_cfg.window_width = val[7:0];
      REG_BRIGHTNESS_LIMITS: shadow_cfg.brightness_limits = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain;
    while (pending_colours.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random LEDs in bursts; positions mostly near the ring so the fade is exercised.
  task automatic send_bursts(input int count);
    int left, burst, gap;
    logic signed [15:0] x, y;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (burst > left) burst = left;
      gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : 0;
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else begin
          x = shadow_cfg.center_x + shadow_cfg.ring_radius
              + $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
          y = shadow_cfg.center_y + $signed(16'($urandom_range(0, 1023))) - 16'sd512;
        end
        // With no gap after this burst, start stays high into the next one.
        send_led(x, y, 8'($urandom), (i != burst - 1) || (gap == 0 && left > burst));
      end
      left -= burst;
      if (gap > 0) repeat (gap) @(negedge clk);
    end
  endtask

  task automatic test_defaults;
    send_led(16'sh0000, 16'sh0000, 8'd0, 1'b1);
    send_led(16'sh7FFF, 16'sh7FFF, 8'd255, 1'b1);
    send_led(-16'sh8000, -16'sh8000, 8'd31, 1'b1);
    send_led(16'sh7FFF, -16'sh8000, 8'd16, 1'b1);
    send_led(16'sh0080, 16'sh0000, 8'd15, 1'b0);
    drain();
  endtask

  task automatic test_special_settings;
    // Zero fade width, zero window width and a maximum below the minimum.
    write_reg(REG_FADE_WIDTH, 24'd0);
    write_reg(REG_WINDOW_WIDTH, 24'd0);
    write_reg(REG_BRIGHTNESS_LIMITS, 24'h40C0);
    write_reg(REG_COLOR_A, 24'h123456);
    send_led(16'sh0000, 16'sh0000, 8'd7, 1'b1);
    send_led(16'sh0001, 16'sh0000, 8'd8, 1'b0);
    drain();
    // Zero brightness gives black.
    write_reg(REG_BRIGHTNESS_LIMITS, 24'h0000);
    write_reg(REG_FADE_WIDTH, 24'hFFFF);
    write_reg(REG_WINDOW_WIDTH, 24'd255);
    send_led(16'sh0100, 16'sh0100, 8'd3, 1'b0);
    drain();
    write_reg(REG_BRIGHTNESS_LIMITS, 24'hFF00);
    write_reg(REG_CENTER_X, 24'h008000);
    write_reg(REG_CENTER_Y, 24'h007FFF);
    write_reg(REG_RING_RADIUS, 24'h008000);
    write_reg(REG_COLOR_B, 24'h000000);
    write_reg(REG_COLOR_A, 24'hFFFFFF);
    send_led(16'sh7FFF, -16'sh8000, 8'd0, 1'b1);
    send_led(16'sh7FFF, 16'sh7FFF, 8'd128, 1'b0);
    drain();
  endtask

  task automatic test_random_settings;
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(REG_CENTER_X, 24'($urandom));
      write_reg(REG_CENTER_Y, 24'($urandom));
      write_reg(REG_RING_RADIUS,
                (phase % 3 == 0) ? 24'($urandom) : 24'($urandom_range(0, 8192)));
      write_reg(REG_FADE_WIDTH,
                (phase % 4 == 0) ? 24'($urandom) : 24'($urandom_range(1, 1024)));
      write_reg(REG_COLOR_A, 24'($urandom));
      write_reg(REG_COLOR_B, 24'($urandom));
      write_reg(REG_WINDOW_WIDTH, 24'($urandom));
      write_reg(REG_BRIGHTNESS_LIMITS, 24'($urandom));
      send_bursts(110);
      drain();
    end
  endtask

  initial begin
    shadow_cfg = '{center_x: '0, center_y: '0, ring_radius: '0,
                   fade_width: FADE_WIDTH_RST, color_a: '0, color_b: COLOR_B_RST,
                   window_width: WINDOW_WIDTH_RST,
                   brightness_limits: BRIGHTNESS_LIMITS_RST};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_special_settings();
    test_random_settings();
    repeat (LATENCY + 8) @(negedge clk);
    if (errors == 0 && pending_colours.size() == 0)
      $display("tb_radial_ring_led_shader passed");
    else
      $display("tb_radial_ring_led_shader failed");
    $finish;
  end
endmodule
